>>> rtl/round_robin_lock_handoff_defines.svh
`ifndef ROUND_ROBIN_LOCK_HANDOFF_DEFINES_SVH
`define ROUND_ROBIN_LOCK_HANDOFF_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRLH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rrlh assertion failed");

// next-cycle implication, checked outside reset
`define RRLH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rrlh assertion failed");

`endif

>>> rtl/rrlh_pkg.sv
`default_nettype none

package rrlh_pkg;

	// payload widths
	localparam int OP_W    = 1;
	localparam int CORE_W  = 4;
	localparam int EVENT_W = 2;
	localparam int GSLOT_W = 4;
	localparam int CC_W    = 5;
	localparam int MAP_W   = 64;
	localparam int CIDX_W  = 1;

	// register reset values
	localparam logic [MAP_W-1:0] ROUTE_MAP_RST  = 64'h8AF0_CDEB_1267_5493;
	localparam logic [CC_W-1:0]  CORE_COUNT_RST = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_GRANT = 2'd0,
		EV_QUEUE = 2'd1,
		EV_HAND  = 2'd2,
		EV_FREE  = 2'd3
	} event_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_ROUTE_MAP  = 1'b0,
		REG_CORE_COUNT = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/rrlh_ifs.sv
`default_nettype none

// request channel: one acquire or release per beat
interface rrlh_req_if;
	logic                          valid;
	logic                          ready;
	logic [rrlh_pkg::OP_W-1:0]     opcode;
	logic [rrlh_pkg::CORE_W-1:0]   core_id;

	modport source (output valid, output opcode, output core_id, input ready);
	modport sink   (input valid, input opcode, input core_id, output ready);
endinterface

// result channel: one event per request
interface rrlh_res_if;
	logic                          valid;
	logic                          ready;
	logic [rrlh_pkg::EVENT_W-1:0]  event_res;
	logic [rrlh_pkg::GSLOT_W-1:0]  grant_slot;
	logic                          lock_held;

	modport source (output valid, output event_res, output grant_slot, output lock_held,
		input ready);
	modport sink   (input valid, input event_res, input grant_slot, input lock_held,
		output ready);
endinterface

// register write channel
interface rrlh_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rrlh_pkg::CIDX_W-1:0]   index;
	logic [rrlh_pkg::MAP_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rrlh_scan.sv
`default_nettype none

// circular search for the first waiting slot after the start slot
module rrlh_scan #(
	parameter int SLOTS = 16,
	parameter int SW    = 4
) (
	input  logic [SLOTS-1:0] flags,
	input  logic [SW-1:0]    start,
	output logic             found,
	output logic [SW-1:0]    pos
);

	logic [SLOTS-1:0] above;
	logic [SLOTS-1:0] sel;

	// slots strictly after start; flags beyond the live count are always clear,
	// so falling back to the lowest flag wraps around and ends on start itself
	assign above = flags & (({SLOTS{1'b1}} << start) << 1);
	assign sel   = (|above) ? above : flags;
	assign found = |flags;

	// lowest set bit of the selected vector
	always_comb begin
		pos = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (sel[i]) begin
				pos = SW'(i);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/round_robin_lock_handoff.sv
// a request beat is held in the input register, its event in the result register
// throughput: one request per cycle unless the result channel stalls; the two
//   registers decouple the two channels, and the handoff scan is one rotated priority encode
// reset: wait flags and lock cleared, route map and core count at defaults,
//   both pipeline stages empty; register writes are taken in every cycle
`default_nettype none

module round_robin_lock_handoff #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rrlh_req_if.sink    req,
	rrlh_res_if.source  res,
	rrlh_cfg_if.sink    cfg
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(SLOTS + 1);
	localparam int RW = NW + 4;

	// configuration registers
	logic [rrlh_pkg::MAP_W-1:0] route_q;
	logic [rrlh_pkg::CC_W-1:0]  cc_q;

	// lock state
	logic [SLOTS-1:0] flags_q;
	logic             busy_q;

	// input stage
	logic                        valid_s1;
	logic [rrlh_pkg::OP_W-1:0]   op_s1;
	logic [rrlh_pkg::CORE_W-1:0] core_s1;

	// result stage
	logic                           valid_s2;
	rrlh_pkg::event_t               ev_s2;
	logic [rrlh_pkg::GSLOT_W-1:0]   gs_s2;
	logic                           held_s2;

	logic             advance;
	logic             cc_we;
	logic [NW-1:0]    n_live;
	logic [NW-1:0]    n_new;
	logic [SLOTS-1:0] keep_mask;
	logic [3:0]       entry;
	logic [SW-1:0]    slot;
	logic             found;
	logic [SW-1:0]    pos;
	logic [SLOTS-1:0] flags_nx;
	logic             busy_nx;
	rrlh_pkg::event_t ev_nx;
	logic [SW-1:0]    gs_nx;

	// clamp the core count into 1..SLOTS
	function automatic logic [NW-1:0] clamp_n(input logic [rrlh_pkg::CC_W-1:0] c);
		logic [NW-1:0] r;
		if (c == '0) begin
			r = NW'(1);
		end else if (int'(c) > SLOTS) begin
			r = NW'(SLOTS);
		end else begin
			r = NW'(c);
		end
		return r;
	endfunction

	assign n_live = clamp_n(cc_q);
	assign n_new  = clamp_n(cfg.data[rrlh_pkg::CC_W-1:0]);
	assign cc_we  = cfg.valid && cfg.ready && (cfg.index == rrlh_pkg::REG_CORE_COUNT);

	// slots kept when the count is lowered
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			keep_mask[i] = (i < int'(n_new));
		end
	end

	// handshake
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// routing slot: map entry reduced modulo the live count, restoring steps
	assign entry = route_q[{core_s1, 2'b00} +: 4];

	always_comb begin
		logic [RW-1:0] r;
		logic [RW-1:0] d;
		r = RW'(entry);
		for (int k = 3; k >= 0; k--) begin
			d = RW'(n_live) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		slot = SW'(r);
	end

	rrlh_scan #(
		.SLOTS(SLOTS),
		.SW   (SW)
	) u_scan (
		.flags(flags_q),
		.start(slot),
		.found(found),
		.pos  (pos)
	);

	// acquire or release against the current state
	always_comb begin
		flags_nx = flags_q;
		busy_nx  = busy_q;
		ev_nx    = rrlh_pkg::EV_FREE;
		gs_nx    = '0;
		if (op_s1 == rrlh_pkg::OP_ACQUIRE) begin
			if (!busy_q) begin
				busy_nx = 1'b1;
				ev_nx   = rrlh_pkg::EV_GRANT;
				gs_nx   = slot;
			end else begin
				flags_nx[slot] = 1'b1;
				ev_nx          = rrlh_pkg::EV_QUEUE;
			end
		end else if (found) begin
			flags_nx[pos] = 1'b0;
			busy_nx       = 1'b1;
			ev_nx         = rrlh_pkg::EV_HAND;
			gs_nx         = pos;
		end else begin
			busy_nx = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_q <= rrlh_pkg::ROUTE_MAP_RST;
			cc_q    <= rrlh_pkg::CORE_COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == rrlh_pkg::REG_ROUTE_MAP) begin
				route_q <= cfg.data;
			end else begin
				cc_q <= cfg.data[rrlh_pkg::CC_W-1:0];
			end
		end
	end

	// lock state; a lowered count drops flags that the scan can no longer reach
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (advance) begin
				busy_q <= busy_nx;
			end
			if (cc_we) begin
				flags_q <= (advance ? flags_nx : flags_q) & keep_mask;
			end else if (advance) begin
				flags_q <= flags_nx;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.opcode;
			core_s1 <= req.core_id;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_s2   <= ev_nx;
			gs_s2   <= rrlh_pkg::GSLOT_W'(gs_nx);
			held_s2 <= busy_nx;
		end
	end

	assign res.valid      = valid_s2;
	assign res.event_res  = ev_s2;
	assign res.grant_slot = gs_s2;
	assign res.lock_held  = held_s2;

endmodule

`default_nettype wire

>>> rtl/rrlh_chk.sv
`default_nettype none
`include "round_robin_lock_handoff_defines.svh"

// port-level checks on the result channel
module rrlh_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [rrlh_pkg::EVENT_W-1:0]   event_res,
	input logic [rrlh_pkg::GSLOT_W-1:0]   grant_slot,
	input logic                           lock_held
);

	logic grant_ev;
	logic queue_ev;
	logic free_ev;
	logic stall;
	logic [rrlh_pkg::EVENT_W+rrlh_pkg::GSLOT_W:0] res_beat;

	assign grant_ev = res_valid && ((event_res == rrlh_pkg::EV_GRANT) ||
		(event_res == rrlh_pkg::EV_HAND));
	assign queue_ev = res_valid && (event_res == rrlh_pkg::EV_QUEUE);
	assign free_ev  = res_valid && (event_res == rrlh_pkg::EV_FREE);
	assign stall    = res_valid && !res_ready;
	assign res_beat = {event_res, grant_slot, lock_held};

	// a stalled result beat holds
	`RRLH_ASSERT_NEXT(a_stall_hold, clk, arst_n, stall, res_valid && $stable(res_beat))
	// a grant or handoff leaves the lock held
	`RRLH_ASSERT_NOW(a_grant_held, clk, arst_n, grant_ev, lock_held)
	// queuing only happens on a held lock and reports no slot
	`RRLH_ASSERT_NOW(a_queue_held, clk, arst_n, queue_ev, lock_held && (grant_slot == '0))
	// freeing leaves the lock free and reports no slot
	`RRLH_ASSERT_NOW(a_free_clear, clk, arst_n, free_ev, !lock_held && (grant_slot == '0))

endmodule

bind round_robin_lock_handoff rrlh_chk u_rrlh_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.event_res (res.event_res),
	.grant_slot(res.grant_slot),
	.lock_held (res.lock_held)
);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 1400;
	localparam int IDLE_LIMIT   = 2000;

	// one expected lock event per request beat
	typedef struct packed {
		rrlh_pkg::event_t             ev;
		logic [rrlh_pkg::GSLOT_W-1:0] slot;
		logic                         held;
	} lock_event_t;

	// mirror of the lock state; predicts the event of each request
	class handoff_scoreboard;
		logic [rrlh_pkg::MAP_W-1:0] route_map;
		logic [rrlh_pkg::CC_W-1:0]  core_count;
		logic [SLOTS-1:0]           wait_flags;
		logic                       busy;
		lock_event_t                expected_events[$];
		int                         errors;

		function new();
			route_map  = rrlh_pkg::ROUTE_MAP_RST;
			core_count = rrlh_pkg::CORE_COUNT_RST;
			wait_flags = '0;
			busy       = 1'b0;
			errors     = 0;
		endfunction

		// effective slot count, clamped to 1..SLOTS
		function int live_slots();
			int n;
			n = core_count;
			if (n == 0)
				n = 1;
			if (n > SLOTS)
				n = SLOTS;
			return n;
		endfunction

		function void write_reg(rrlh_pkg::cfg_reg_t idx, logic [rrlh_pkg::MAP_W-1:0] data);
			int n;
			int s;
			if (idx == rrlh_pkg::REG_ROUTE_MAP) begin
				route_map = data;
			end else begin
				core_count = data[rrlh_pkg::CC_W-1:0];
				// flags beyond the new count can never be scanned
				n = live_slots();
				for (s = n; s < SLOTS; s++)
					wait_flags[s] = 1'b0;
			end
		endfunction

		function void note_request(rrlh_pkg::op_t op, logic [rrlh_pkg::CORE_W-1:0] core);
			int          n;
			int          slot;
			int          pos;
			int          i;
			bit          found;
			lock_event_t e;
			n      = live_slots();
			slot   = int'(route_map[int'(core) * 4 +: 4]) % n;
			e.ev   = rrlh_pkg::EV_FREE;
			e.slot = '0;
			e.held = 1'b0;
			if (op == rrlh_pkg::OP_ACQUIRE) begin
				if (!busy) begin
					busy   = 1'b1;
					e.ev   = rrlh_pkg::EV_GRANT;
					e.slot = rrlh_pkg::GSLOT_W'(slot);
				end else begin
					wait_flags[slot] = 1'b1;
					e.ev             = rrlh_pkg::EV_QUEUE;
				end
			end else begin
				// circular scan after the releaser, own slot visited last
				found = 1'b0;
				for (i = 1; i <= n && !found; i++) begin
					pos = (slot + i) % n;
					if (wait_flags[pos]) begin
						wait_flags[pos] = 1'b0;
						busy            = 1'b1;
						e.ev            = rrlh_pkg::EV_HAND;
						e.slot          = rrlh_pkg::GSLOT_W'(pos);
						found           = 1'b1;
					end
				end
				if (!found)
					busy = 1'b0;
			end
			e.held = busy;
			expected_events.push_back(e);
		endfunction

		function void check_result(logic [rrlh_pkg::EVENT_W-1:0] ev,
			logic [rrlh_pkg::GSLOT_W-1:0] slot, logic held);
			lock_event_t want;
			if (expected_events.size() == 0) begin
				$error("result beat with nothing pending: event_res %0d grant_slot %0d",
					ev, slot);
				errors++;
				return;
			end
			want = expected_events.pop_front();
			if (ev !== want.ev) begin
				$error("event_res: expected %0d, actual %0d", want.ev, ev);
				errors++;
			end
			if (slot !== want.slot) begin
				$error("grant_slot: expected %0d, actual %0d", want.slot, slot);
				errors++;
			end
			if (held !== want.held) begin
				$error("lock_held: expected %0d, actual %0d", want.held, held);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   idle_cycles;

	handoff_scoreboard sb;

	rrlh_req_if req_ch ();
	rrlh_res_if res_ch ();
	rrlh_cfg_if cfg_ch ();

	round_robin_lock_handoff dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none at all in calm phases
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(rrlh_pkg::op_t op, logic [rrlh_pkg::CORE_W-1:0] core);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= op;
		req_ch.core_id <= core;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(op, core);
	endtask

	task automatic write_register(rrlh_pkg::cfg_reg_t idx, logic [rrlh_pkg::MAP_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop requests and let every pending event come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side back-pressure
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.event_res, res_ch.grant_slot, res_ch.lock_held);
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main sequence
	initial begin
		int                         sent;
		int                         n_items;
		int                         acq_pct;
		int                         pick;
		rrlh_pkg::op_t              op;
		logic [rrlh_pkg::MAP_W-1:0] map_val;
		logic [rrlh_pkg::CC_W-1:0]  count_val;

		sb          = new();
		calm        = 1'b0;
		sent        = 0;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= rrlh_pkg::OP_ACQUIRE;
		req_ch.core_id <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= rrlh_pkg::REG_ROUTE_MAP;
		cfg_ch.data    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default map: grant, queue, holder re-acquire, handoffs, free releases
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd0);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd1);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd15);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd0);
		send_request(rrlh_pkg::OP_RELEASE, 4'd0);
		send_request(rrlh_pkg::OP_RELEASE, 4'd3);
		send_request(rrlh_pkg::OP_RELEASE, 4'd15);
		send_request(rrlh_pkg::OP_RELEASE, 4'd7);
		send_request(rrlh_pkg::OP_RELEASE, 4'd7);
		// releaser's own slot waiting is served last
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd5);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd9);
		send_request(rrlh_pkg::OP_RELEASE, 4'd9);
		send_request(rrlh_pkg::OP_RELEASE, 4'd9);
		drain();

		// zero count acts as one slot, every core lands on slot 0
		write_register(rrlh_pkg::REG_ROUTE_MAP, '1);
		write_register(rrlh_pkg::REG_CORE_COUNT, 64'd0);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd3);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd4);
		send_request(rrlh_pkg::OP_RELEASE, 4'd4);
		send_request(rrlh_pkg::OP_RELEASE, 4'd4);
		drain();

		// count above the slot range, identity map
		write_register(rrlh_pkg::REG_ROUTE_MAP, 64'hFEDC_BA98_7654_3210);
		write_register(rrlh_pkg::REG_CORE_COUNT, 64'd31);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd15);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd14);
		send_request(rrlh_pkg::OP_RELEASE, 4'd15);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd2);
		send_request(rrlh_pkg::OP_ACQUIRE, 4'd12);
		drain();

		// lowering the count drops flags above it; map entries wrap modulo the count
		write_register(rrlh_pkg::REG_CORE_COUNT, 64'd5);
		send_request(rrlh_pkg::OP_RELEASE, 4'd14);
		send_request(rrlh_pkg::OP_RELEASE, 4'd2);
		drain();

		// random phases, each with its own settings and mix
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 7);
			case (pick)
				0: map_val = '0;
				1: map_val = '1;
				2: map_val = 64'hFEDC_BA98_7654_3210;
				default: map_val = {$urandom, $urandom};
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0: count_val = 5'd0;
				1: count_val = 5'd1;
				2: count_val = 5'd16;
				3: count_val = 5'($urandom_range(17, 31));
				default: count_val = 5'($urandom_range(2, 15));
			endcase
			pick = $urandom_range(0, 3);
			if (pick != 1)
				write_register(rrlh_pkg::REG_ROUTE_MAP, map_val);
			if (pick != 0)
				write_register(rrlh_pkg::REG_CORE_COUNT,
					{{(rrlh_pkg::MAP_W-rrlh_pkg::CC_W){1'b0}}, count_val});

			n_items = $urandom_range(40, 160);
			if (n_items > RANDOM_ITEMS - sent)
				n_items = RANDOM_ITEMS - sent;
			acq_pct = $urandom_range(30, 75);
			repeat (n_items) begin
				op = ($urandom_range(0, 99) < acq_pct) ? rrlh_pkg::OP_ACQUIRE
					: rrlh_pkg::OP_RELEASE;
				send_request(op, rrlh_pkg::CORE_W'($urandom_range(0, 15)));
				sent++;
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_events.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
